### sv/dpb_pkg.sv
package dpb_pkg;

	// Fixed-point format of the results
	localparam int FRAC_BITS = 16;

	// Field widths
	localparam int DEPTH_W = 16;
	localparam int COORD_W = 12;
	localparam int COLOR_W = 8;
	localparam int RECIP_W = 24;
	localparam int CENTER_W = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int POINT_W = 32;
	localparam int ZOUT_W = 31;

	// Derived arithmetic widths
	localparam int ZFULL_W = DEPTH_W + RECIP_W;          // Q.24 depth
	localparam int OFF_W = CENTER_W + 1;                 // signed half-pixel offset
	localparam int MAG_W = CENTER_W;                     // offset magnitude
	localparam int A_W = MAG_W + RECIP_W;                // offset over focal length
	localparam int ZL_W = ZFULL_W / 2;                   // low slice of depth
	localparam int ZH_W = ZFULL_W - ZL_W;                // high slice of depth
	localparam int PPL_W = A_W + ZL_W;
	localparam int PPH_W = A_W + ZH_W;
	localparam int PROD_W = A_W + ZFULL_W;
	localparam int LAT_SHIFT = 49 - FRAC_BITS;
	localparam int LAT_R_W = PROD_W + 1 - LAT_SHIFT;
	localparam int Z_SHIFT = 24 - FRAC_BITS;
	localparam int ZR_W = ZFULL_W + 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FY = 3'd4;

	// Register reset values
	localparam logic [RECIP_W-1:0] RST_DEPTH_SCALE = 24'd16777;
	localparam logic [CENTER_W-1:0] RST_CENTER_X = 13'd651;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y = 13'd507;
	localparam logic [RECIP_W-1:0] RST_INV_FX = 24'd32388;
	localparam logic [RECIP_W-1:0] RST_INV_FY = 24'd32326;

	// Side data carried along the pipeline with each item
	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
		logic frame_end;
		logic point_ok;
	} pix_t;

endpackage

### sv/depth_pixel_backprojection.sv
// Back-projection of RGB-D pixels to fixed-point 3D points.
// Input channel: in_valid / in_stall with depth_raw, pixel_column, pixel_row,
// the color bytes and frame_end_in. An item is taken when in_valid is high
// and in_stall is low. Output channel: out_valid / out_stall with point_x,
// point_y, point_z, color bytes, point_valid and frame_end_out.
// Configuration: cfg_valid / cfg_ready (always ready) with cfg_index and
// cfg_data; write only while no item is in flight.
// An item taken at the input passes the five stages (depth product, focal
// product, split depth partial products, sum and round, saturate) before
// out_valid shows it; one item per cycle is sustained while out_stall holds
// no waiting result, since each stage then takes a new item every cycle.
// Pixels with zero depth that do not end a frame are dropped at the input
// stage and give no result.
// Reset clears all stage valid bits and loads the default camera intrinsics.
// While out_stall holds a waiting result, the whole pipeline holds and
// in_stall is raised; nothing is lost or repeated.
module depth_pixel_backprojection (
	input  logic clk,
	input  logic arst_n,
	// configuration write
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [dpb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data,
	// input pixels
	input  logic in_valid,
	output logic in_stall,
	input  logic [dpb_pkg::DEPTH_W-1:0] depth_raw,
	input  logic [dpb_pkg::COORD_W-1:0] pixel_column,
	input  logic [dpb_pkg::COORD_W-1:0] pixel_row,
	input  logic [dpb_pkg::COLOR_W-1:0] blue_in,
	input  logic [dpb_pkg::COLOR_W-1:0] green_in,
	input  logic [dpb_pkg::COLOR_W-1:0] red_in,
	input  logic frame_end_in,
	// output points
	output logic out_valid,
	input  logic out_stall,
	output logic signed [dpb_pkg::POINT_W-1:0] point_x,
	output logic signed [dpb_pkg::POINT_W-1:0] point_y,
	output logic [dpb_pkg::ZOUT_W-1:0] point_z,
	output logic [dpb_pkg::COLOR_W-1:0] blue_out,
	output logic [dpb_pkg::COLOR_W-1:0] green_out,
	output logic [dpb_pkg::COLOR_W-1:0] red_out,
	output logic point_valid,
	output logic frame_end_out
);

	localparam int ZFULL_W = dpb_pkg::ZFULL_W;
	localparam int MAG_W = dpb_pkg::MAG_W;
	localparam int OFF_W = dpb_pkg::OFF_W;
	localparam int A_W = dpb_pkg::A_W;
	localparam int ZL_W = dpb_pkg::ZL_W;
	localparam int PPL_W = dpb_pkg::PPL_W;
	localparam int PPH_W = dpb_pkg::PPH_W;
	localparam int PROD_W = dpb_pkg::PROD_W;
	localparam int LAT_SHIFT = dpb_pkg::LAT_SHIFT;
	localparam int LAT_R_W = dpb_pkg::LAT_R_W;
	localparam int Z_SHIFT = dpb_pkg::Z_SHIFT;
	localparam int ZR_W = dpb_pkg::ZR_W;
	localparam int POINT_W = dpb_pkg::POINT_W;
	localparam int ZOUT_W = dpb_pkg::ZOUT_W;

	localparam logic [PROD_W:0] LAT_HALF = (PROD_W + 1)'(1) << (LAT_SHIFT - 1);
	localparam logic [ZR_W-1:0] Z_HALF = ZR_W'(1) << Z_SHIFT;
	localparam logic [LAT_R_W-1:0] LIM_POS = LAT_R_W'(32'h7fff_ffff);
	localparam logic [LAT_R_W-1:0] LIM_NEG = LAT_R_W'(33'h0_8000_0000);
	localparam logic [ZR_W-1:0] Z_MAX = ZR_W'(32'h7fff_ffff);

	// Configuration registers
	logic [dpb_pkg::RECIP_W-1:0] depth_scale_q;
	logic [dpb_pkg::CENTER_W-1:0] center_x_q;
	logic [dpb_pkg::CENTER_W-1:0] center_y_q;
	logic [dpb_pkg::RECIP_W-1:0] inv_fx_q;
	logic [dpb_pkg::RECIP_W-1:0] inv_fy_q;

	assign cfg_ready = 1'b1;

	// Load the addressed register; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_scale_q <= dpb_pkg::RST_DEPTH_SCALE;
			center_x_q <= dpb_pkg::RST_CENTER_X;
			center_y_q <= dpb_pkg::RST_CENTER_Y;
			inv_fx_q <= dpb_pkg::RST_INV_FX;
			inv_fy_q <= dpb_pkg::RST_INV_FY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dpb_pkg::REG_DEPTH_SCALE: depth_scale_q <= cfg_data[dpb_pkg::RECIP_W-1:0];
				dpb_pkg::REG_CENTER_X: center_x_q <= cfg_data[dpb_pkg::CENTER_W-1:0];
				dpb_pkg::REG_CENTER_Y: center_y_q <= cfg_data[dpb_pkg::CENTER_W-1:0];
				dpb_pkg::REG_INV_FX: inv_fx_q <= cfg_data[dpb_pkg::RECIP_W-1:0];
				dpb_pkg::REG_INV_FY: inv_fy_q <= cfg_data[dpb_pkg::RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline advance: hold everything while a result waits at the output
	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Stage 1: depth product and lateral offsets
	logic signed [OFF_W-1:0] off_x, off_y;
	logic [OFF_W-1:0] abs_x, abs_y;
	logic keep;

	always_comb begin
		off_x = $signed({1'b0, pixel_column, 1'b0}) - $signed({1'b0, center_x_q});
		off_y = $signed({1'b0, pixel_row, 1'b0}) - $signed({1'b0, center_y_q});
		abs_x = off_x[OFF_W-1] ? OFF_W'(-off_x) : OFF_W'(off_x);
		abs_y = off_y[OFF_W-1] ? OFF_W'(-off_y) : OFF_W'(off_y);
		keep = (depth_raw != '0) || frame_end_in;
	end

	logic v_s1;
	dpb_pkg::pix_t pix_s1;
	logic [ZFULL_W-1:0] zfull_s1;
	logic [MAG_W-1:0] magx_s1, magy_s1;
	logic negx_s1, negy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1 <= '{blue: blue_in, green: green_in, red: red_in,
				frame_end: frame_end_in, point_ok: depth_raw != '0};
			zfull_s1 <= ZFULL_W'(depth_raw) * ZFULL_W'(depth_scale_q);
			magx_s1 <= abs_x[MAG_W-1:0];
			magy_s1 <= abs_y[MAG_W-1:0];
			negx_s1 <= off_x[OFF_W-1];
			// row direction is flipped
			negy_s1 <= !off_y[OFF_W-1];
		end
	end

	// Stage 2: scale offsets by reciprocal focal lengths, round depth
	logic [ZR_W-1:0] z_round;
	logic [ZR_W-1:0] z_sat;

	always_comb begin
		z_round = (({2'b0, zfull_s1} << 1) + Z_HALF) >> (Z_SHIFT + 1);
		z_sat = (z_round > Z_MAX) ? Z_MAX : z_round;
	end

	logic v_s2;
	dpb_pkg::pix_t pix_s2;
	logic [ZFULL_W-1:0] zfull_s2;
	logic [ZOUT_W-1:0] zq_s2;
	logic [A_W-1:0] ax_s2, ay_s2;
	logic negx_s2, negy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s2 <= pix_s1;
			zfull_s2 <= zfull_s1;
			zq_s2 <= z_sat[ZOUT_W-1:0];
			ax_s2 <= A_W'(magx_s1) * A_W'(inv_fx_q);
			ay_s2 <= A_W'(magy_s1) * A_W'(inv_fy_q);
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
		end
	end

	// Stage 3: partial products against low and high halves of depth
	logic v_s3;
	dpb_pkg::pix_t pix_s3;
	logic [ZOUT_W-1:0] zq_s3;
	logic [PPL_W-1:0] pxl_s3, pyl_s3;
	logic [PPH_W-1:0] pxh_s3, pyh_s3;
	logic negx_s3, negy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s3 <= pix_s2;
			zq_s3 <= zq_s2;
			pxl_s3 <= PPL_W'(ax_s2) * PPL_W'(zfull_s2[ZL_W-1:0]);
			pxh_s3 <= PPH_W'(ax_s2) * PPH_W'(zfull_s2[ZFULL_W-1:ZL_W]);
			pyl_s3 <= PPL_W'(ay_s2) * PPL_W'(zfull_s2[ZL_W-1:0]);
			pyh_s3 <= PPH_W'(ay_s2) * PPH_W'(zfull_s2[ZFULL_W-1:ZL_W]);
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
		end
	end

	// Stage 4: combine partial products and round on the magnitude
	logic [PROD_W:0] sum_x, sum_y;

	always_comb begin
		sum_x = (PROD_W + 1)'(pxl_s3) + ((PROD_W + 1)'(pxh_s3) << ZL_W) + LAT_HALF;
		sum_y = (PROD_W + 1)'(pyl_s3) + ((PROD_W + 1)'(pyh_s3) << ZL_W) + LAT_HALF;
	end

	logic v_s4;
	dpb_pkg::pix_t pix_s4;
	logic [ZOUT_W-1:0] zq_s4;
	logic [LAT_R_W-1:0] rx_s4, ry_s4;
	logic negx_s4, negy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s4 <= pix_s3;
			zq_s4 <= zq_s3;
			rx_s4 <= sum_x[PROD_W:LAT_SHIFT];
			ry_s4 <= sum_y[PROD_W:LAT_SHIFT];
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
		end
	end

	// Stage 5: saturate, apply sign, present the result
	logic [LAT_R_W-1:0] lim_x, lim_y, satx, saty;
	logic [POINT_W-1:0] fx, fy;

	always_comb begin
		lim_x = negx_s4 ? LIM_NEG : LIM_POS;
		lim_y = negy_s4 ? LIM_NEG : LIM_POS;
		satx = (rx_s4 > lim_x) ? lim_x : rx_s4;
		saty = (ry_s4 > lim_y) ? lim_y : ry_s4;
		fx = negx_s4 ? (POINT_W'(0) - satx[POINT_W-1:0]) : satx[POINT_W-1:0];
		fy = negy_s4 ? (POINT_W'(0) - saty[POINT_W-1:0]) : saty[POINT_W-1:0];
	end

	logic v_s5;
	dpb_pkg::pix_t pix_s5;
	logic [POINT_W-1:0] x_s5, y_s5;
	logic [ZOUT_W-1:0] z_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s5 <= pix_s4;
			x_s5 <= fx;
			y_s5 <= fy;
			z_s5 <= zq_s4;
		end
	end

	// Drive the output channel
	assign out_valid = v_s5;
	assign point_x = $signed(x_s5);
	assign point_y = $signed(y_s5);
	assign point_z = z_s5;
	assign blue_out = pix_s5.blue;
	assign green_out = pix_s5.green;
	assign red_out = pix_s5.red;
	assign point_valid = pix_s5.point_ok;
	assign frame_end_out = pix_s5.frame_end;

endmodule
